// ===== src/qpcp_pkg.sv =====
// shared types, constants and key tables for the query pair command parser
package qpcp_pkg;

  // longest payload that still parses, in bytes
  localparam int MaxPayload = 256;
  // byte counter holds up to MaxPayload + 1
  localparam int CountW = $clog2(MaxPayload + 2);

  // value and accumulator limits
  localparam int ValueMaxChars = 11;
  localparam logic [16:0] AccCap = 17'd65536;
  localparam logic [16:0] PumpMax = 17'd255;

  // characters with a meaning of their own
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChVtab = 8'h0b;
  localparam logic [7:0] ChFormfeed = 8'h0c;
  localparam logic [7:0] ChReturn = 8'h0d;
  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChEq = 8'h3d;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // which key a field unit looks for
  typedef enum logic {
    KEY_PUMP,
    KEY_DUR
  } qpcp_key_t;

  // field parse phase
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_KEYED,
    PH_VALUE,
    PH_ENDED,
    PH_FAIL
  } qpcp_phase_t;

  // per-field summary handed to the top level, taken after the current byte
  typedef struct packed {
    logic ok;
    logic neg;
    logic [16:0] acc;
  } qpcp_fstat_t;

  // key length
  function automatic logic [3:0] key_len(qpcp_key_t sel);
    return (sel == KEY_PUMP) ? 4'd7 : 4'd10;
  endfunction

  // key character at a position
  function automatic logic [7:0] key_char(qpcp_key_t sel, logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (sel == KEY_PUMP) begin
      unique case (idx)
        4'd0: ch = "p";
        4'd1: ch = "u";
        4'd2: ch = "m";
        4'd3: ch = "p";
        4'd4: ch = "_";
        4'd5: ch = "i";
        4'd6: ch = "d";
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (idx)
        4'd0: ch = "d";
        4'd1: ch = "u";
        4'd2: ch = "r";
        4'd3: ch = "a";
        4'd4: ch = "t";
        4'd5: ch = "i";
        4'd6: ch = "o";
        4'd7: ch = "n";
        4'd8: ch = "_";
        4'd9: ch = "s";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  // prefix matcher step with fallback; "pump" falls back to "p" on a miss
  function automatic logic [3:0] key_step(qpcp_key_t sel, logic [3:0] k, logic [7:0] c);
    logic [3:0] res;
    if (key_char(sel, k) == c) begin
      res = k + 4'd1;
    end else if (sel == KEY_PUMP && k == 4'd4 && c == key_char(sel, 4'd1)) begin
      res = 4'd2;
    end else if (c == key_char(sel, 4'd0)) begin
      res = 4'd1;
    end else begin
      res = 4'd0;
    end
    return res;
  endfunction

endpackage

// ===== src/qpcp_field.sv =====
// key matcher and value reader for one field of the command
module qpcp_field (
  input  logic                clk,
  input  logic                rst_n,
  input  qpcp_pkg::qpcp_key_t key_sel,
  input  logic                step,
  input  logic                clear,
  input  logic [7:0]          data_byte,
  output qpcp_pkg::qpcp_fstat_t stat
);
  import qpcp_pkg::*;

  logic [3:0]  progress_r, progress_nxt;
  qpcp_phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        started_r, started_nxt;
  logic        stopped_r, stopped_nxt;
  logic [19:0] prod;
  logic        is_digit;

  // multiply-by-ten accumulate on the current byte
  assign is_digit = (data_byte >= ChZero) && (data_byte <= ChNine);
  assign prod = {3'b000, acc_r} * 20'd10 + {12'h000, data_byte - ChZero};

  // next field state for a non-whitespace byte
  always_comb begin
    progress_nxt = progress_r;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    started_nxt = started_r;
    stopped_nxt = stopped_r;
    if (step) begin
      unique case (phase_r)
        PH_SEARCH: begin
          progress_nxt = key_step(key_sel, progress_r, data_byte);
          if (progress_nxt == key_len(key_sel)) begin
            phase_nxt = PH_KEYED;
          end
        end
        PH_KEYED: begin
          phase_nxt = (data_byte == ChEq) ? PH_VALUE : PH_FAIL;
        end
        PH_VALUE: begin
          if (data_byte == ChAmp) begin
            phase_nxt = PH_ENDED;
          end else if (cnt_r >= 4'(ValueMaxChars)) begin
            phase_nxt = PH_FAIL;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
            // atoi-style number reading
            if (!stopped_r) begin
              if (is_digit) begin
                acc_nxt = (prod > {3'b000, AccCap}) ? AccCap : prod[16:0];
                started_nxt = 1'b1;
              end else if (!started_r) begin
                if (data_byte == ChVtab || data_byte == ChFormfeed ||
                    data_byte == ChReturn) begin
                  started_nxt = 1'b0;
                end else if (data_byte == ChPlus) begin
                  started_nxt = 1'b1;
                end else if (data_byte == ChMinus) begin
                  started_nxt = 1'b1;
                  neg_nxt = 1'b1;
                end else begin
                  stopped_nxt = 1'b1;
                end
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // summary seen by the result check
  assign stat.ok = (phase_nxt == PH_VALUE) || (phase_nxt == PH_ENDED);
  assign stat.neg = neg_nxt;
  assign stat.acc = acc_nxt;

  // field state registers, cleared after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      progress_r <= '0;
      phase_r <= PH_SEARCH;
      cnt_r <= '0;
      acc_r <= '0;
      neg_r <= 1'b0;
      started_r <= 1'b0;
      stopped_r <= 1'b0;
    end else if (step) begin
      progress_r <= progress_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== src/query_pair_command_parser.sv =====
// top level of the query pair command parser
//
// Usage: the payload arrives one byte per item on the in_ channel, with
// in_last_byte marking its final byte. Space, tab and newline bytes are
// skipped by the parser. Only the last byte of a payload produces an item on
// the out_ channel: out_valid_res says whether the payload is a well-formed
// pump id / duration key-value command with values in range, and
// out_pump_number / out_duration_seconds carry the values (zero if invalid).
// The result of a last byte is registered and appears in the cycle after it
// is accepted. Throughput: one byte per cycle while in_ready is high; all
// per-byte work (key matchers, counters, one multiply-by-ten accumulate per
// field) sits between the state registers and the output register.
// Reset (rst_n low, synchronous) clears all parse state and the output
// valid flag. When the receiver stalls, the output register holds its item
// and in_ready is low for as long as that item waits, so any byte stalls.
module query_pair_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [7:0]  out_pump_number,
  output logic [15:0] out_duration_seconds
);
  import qpcp_pkg::*;

  logic              accept;
  logic              step;
  logic              clear;
  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic              too_long_r, too_long_nxt;
  logic [1:0]        amp_r, amp_nxt;
  logic [1:0]        eq_r, eq_nxt;
  qpcp_fstat_t       pump_stat, dur_stat;
  logic              ok;
  logic              out_valid_r;
  logic              out_valid_res_r;
  logic [7:0]        out_pump_number_r;
  logic [15:0]       out_duration_seconds_r;

  // handshake: the output register frees the input side
  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;
  assign step = accept && (in_data_byte != ChSpace) && (in_data_byte != ChTab)
                && (in_data_byte != ChNewline);
  assign clear = accept && in_last_byte;

  // length and separator counters
  always_comb begin
    byte_count_nxt = byte_count_r;
    if (byte_count_r <= CountW'(MaxPayload)) begin
      byte_count_nxt = byte_count_r + 1'b1;
    end
    too_long_nxt = too_long_r || (byte_count_nxt > CountW'(MaxPayload));
    amp_nxt = amp_r;
    eq_nxt = eq_r;
    if (step && in_data_byte == ChAmp && amp_r < 2'd2) begin
      amp_nxt = amp_r + 2'd1;
    end
    if (step && in_data_byte == ChEq && eq_r < 2'd3) begin
      eq_nxt = eq_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      byte_count_r <= '0;
      too_long_r <= 1'b0;
      amp_r <= '0;
      eq_r <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      too_long_r <= too_long_nxt;
      amp_r <= amp_nxt;
      eq_r <= eq_nxt;
    end
  end

  // one field unit per key
  qpcp_field u_pump (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_sel   (KEY_PUMP),
    .step      (step),
    .clear     (clear),
    .data_byte (in_data_byte),
    .stat      (pump_stat)
  );

  qpcp_field u_dur (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_sel   (KEY_DUR),
    .step      (step),
    .clear     (clear),
    .data_byte (in_data_byte),
    .stat      (dur_stat)
  );

  // final check on the state after the last byte
  assign ok = !too_long_nxt && (amp_nxt == 2'd1) && (eq_nxt == 2'd2)
              && pump_stat.ok && dur_stat.ok
              && !(pump_stat.neg && pump_stat.acc != 17'd0)
              && (pump_stat.acc <= PumpMax)
              && !(dur_stat.neg && dur_stat.acc != 17'd0)
              && (dur_stat.acc != 17'd0) && (dur_stat.acc < AccCap);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_valid_res_r <= ok;
      out_pump_number_r <= ok ? pump_stat.acc[7:0] : 8'h00;
      out_duration_seconds_r <= ok ? dur_stat.acc[15:0] : 16'h0000;
    end
  end

  assign out_valid = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_pump_number = out_pump_number_r;
  assign out_duration_seconds = out_duration_seconds_r;

endmodule

// ===== bench/query_pair_command_parser_checker.sv =====
// checker for the query pair command parser: tracks payload bytes, predicts and compares results
module query_pair_command_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_valid_res,
  input  logic [7:0]  out_pump_number,
  input  logic [15:0] out_duration_seconds,
  output int          mismatch_count,
  output int          pending
);
  import qpcp_pkg::*;

  // parse progress of one key/value field
  typedef struct packed {
    logic [3:0]  progress;
    qpcp_phase_t phase;
    logic [3:0]  nchars;
    logic [16:0] acc;
    logic        neg;
    logic        started;
    logic        stopped;
  } field_track_t;

  // one expected command verdict
  typedef struct packed {
    logic        ok;
    logic [7:0]  pump;
    logic [15:0] dur;
  } cmd_verdict_t;

  cmd_verdict_t expected_cmds[$];
  field_track_t pump_trk;
  field_track_t dur_trk;
  int nbytes;
  bit overlong;
  int n_amp;
  int n_eq;

  // atoi-style digit accumulation with saturation
  function automatic void feed_digit(inout field_track_t f, input logic [7:0] c);
    int unsigned nxt;
    if (f.stopped) return;
    if (c >= ChZero && c <= ChNine) begin
      nxt = f.acc * 10 + (c - ChZero);
      f.acc = (nxt > AccCap) ? AccCap : nxt[16:0];
      f.started = 1'b1;
    end else if (!f.started) begin
      if (c == ChPlus) begin
        f.started = 1'b1;
      end else if (c == ChMinus) begin
        f.started = 1'b1;
        f.neg = 1'b1;
      end else if (c != ChVtab && c != ChFormfeed && c != ChReturn) begin
        f.stopped = 1'b1;
      end
    end else begin
      f.stopped = 1'b1;
    end
  endfunction

  // advance one field on a non-whitespace byte
  function automatic void scan_field(inout field_track_t f, input logic [7:0] c,
                                     input bit is_pump);
    string key;
    int unsigned k;
    if (is_pump) key = "pump_id";
    else key = {"duration", "_s"};
    case (f.phase)
      PH_SEARCH: begin
        k = f.progress;
        // after a miss on "pump" its last "p" can still open the key
        while (k > 0 && key[k] != c) k = (is_pump && k == 4) ? 1 : 0;
        if (key[k] == c) k++;
        f.progress = k[3:0];
        if (k == key.len()) f.phase = PH_KEYED;
      end
      PH_KEYED: begin
        f.phase = (c == ChEq) ? PH_VALUE : PH_FAIL;
      end
      PH_VALUE: begin
        if (c == ChAmp) begin
          f.phase = PH_ENDED;
        end else if (f.nchars >= ValueMaxChars) begin
          f.phase = PH_FAIL;
        end else begin
          f.nchars++;
          feed_digit(f, c);
        end
      end
      default: ;
    endcase
  endfunction

  // verdict on the payload seen so far
  function automatic cmd_verdict_t judge_command();
    cmd_verdict_t v;
    logic ok;
    ok = !overlong && n_amp == 1 && n_eq == 2
         && (pump_trk.phase == PH_VALUE || pump_trk.phase == PH_ENDED)
         && (dur_trk.phase == PH_VALUE || dur_trk.phase == PH_ENDED);
    if (pump_trk.neg && pump_trk.acc != 0) ok = 1'b0;
    if (pump_trk.acc > PumpMax) ok = 1'b0;
    if (dur_trk.neg && dur_trk.acc != 0) ok = 1'b0;
    if (dur_trk.acc == 0 || dur_trk.acc >= AccCap) ok = 1'b0;
    v.ok = ok;
    v.pump = ok ? pump_trk.acc[7:0] : 8'd0;
    v.dur = ok ? dur_trk.acc[15:0] : 16'd0;
    return v;
  endfunction

  // back to the empty-payload state
  task automatic clear_parse();
    pump_trk = '0;
    pump_trk.phase = PH_SEARCH;
    dur_trk = pump_trk;
    nbytes = 0;
    overlong = 1'b0;
    n_amp = 0;
    n_eq = 0;
  endtask

  initial begin
    mismatch_count = 0;
    pending = 0;
    clear_parse();
  end

  // compare the result item first, then account for the byte taken at this edge
  always @(posedge clk) begin
    cmd_verdict_t want;
    if (!rst_n) begin
      clear_parse();
      expected_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result item valid_res=%0b pump=%0d duration=%0d",
                   $time, out_valid_res, out_pump_number, out_duration_seconds);
        end else begin
          want = expected_cmds.pop_front();
          if (out_valid_res !== want.ok) begin
            mismatch_count++;
            $display("%0t: valid_res expected %0b got %0b", $time, want.ok, out_valid_res);
          end
          if (out_pump_number !== want.pump) begin
            mismatch_count++;
            $display("%0t: pump_number expected %0d got %0d", $time, want.pump,
                     out_pump_number);
          end
          if (out_duration_seconds !== want.dur) begin
            mismatch_count++;
            $display("%0t: duration_seconds expected %0d got %0d", $time, want.dur,
                     out_duration_seconds);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (nbytes <= MaxPayload) nbytes++;
        if (nbytes > MaxPayload) overlong = 1'b1;
        if (in_data_byte != ChSpace && in_data_byte != ChTab && in_data_byte != ChNewline) begin
          if (in_data_byte == ChAmp) begin
            if (n_amp < 2) n_amp++;
          end else if (in_data_byte == ChEq) begin
            if (n_eq < 3) n_eq++;
          end
          scan_field(pump_trk, in_data_byte, 1'b1);
          scan_field(dur_trk, in_data_byte, 1'b0);
        end
        if (in_last_byte) begin
          expected_cmds.push_back(judge_command());
          clear_parse();
        end
      end
    end
    pending = expected_cmds.size();
  end

endmodule

// ===== bench/query_pair_command_parser_tb.sv =====
// testbench top for the query pair command parser: clock, reset, payload stimulus and verdict
module query_pair_command_parser_tb;
  import qpcp_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int TimeoutCycles = 400000;
  localparam int LongStall = 300;
  localparam int PhaseBytes = 350;
  localparam string DurKey = {"duration", "_s"};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_valid_res;
  logic [7:0]  out_pump_number;
  logic [15:0] out_duration_seconds;

  int mismatch_count;
  int pending;

  // stimulus controls
  int tx_gap_pct;
  int rx_gap_pct;
  int stall_req;
  int ws_pct;
  int nsent;
  logic [7:0] pay[$];

  query_pair_command_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_valid_res        (out_valid_res),
    .out_pump_number      (out_pump_number),
    .out_duration_seconds (out_duration_seconds)
  );

  query_pair_command_parser_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_valid_res        (out_valid_res),
    .out_pump_number      (out_pump_number),
    .out_duration_seconds (out_duration_seconds),
    .mismatch_count       (mismatch_count),
    .pending              (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

  // result receiver with random back-pressure and one long hold-off on request
  initial begin
    int seen_stall;
    seen_stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != seen_stall) begin
        seen_stall = stall_req;
        out_ready <= 1'b0;
        repeat (LongStall) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_gap_pct);
    end
  end

  // offer one byte, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    nsent++;
  endtask

  // send the built payload, marking its final byte
  task automatic ship();
    for (int i = 0; i < pay.size(); i++) send_byte(pay[i], i == pay.size() - 1);
  endtask

  // append a byte, sometimes preceded by skipped whitespace
  task automatic put_byte(input logic [7:0] b);
    if (ws_pct > 0 && $urandom_range(99) < ws_pct) begin
      case ($urandom_range(2))
        0: pay.push_back(ChSpace);
        1: pay.push_back(ChTab);
        default: pay.push_back(ChNewline);
      endcase
    end
    pay.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic ship_str(input string s);
    pay.delete();
    put_str(s);
    ship();
  endtask

  // leading spaces count toward length but are skipped by the parser
  task automatic pad_to(input int n);
    while (pay.size() < n) pay.push_front(ChSpace);
  endtask

  // characters close to the command syntax
  function automatic logic [7:0] near_char();
    string s;
    s = "pumpdrations_id=&0123456789+- ";
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // key text, sometimes with a partial key in front or cut short
  task automatic put_key(input bit is_pump);
    string k;
    if (is_pump) k = "pump_id";
    else k = DurKey;
    case ($urandom_range(19))
      0: put_str(is_pump ? "pum" : "dura");
      1: put_str(is_pump ? "p" : "d");
      2: k = k.substr(0, k.len() - 2);
      default: ;
    endcase
    put_str(k);
  endtask

  // value text covering in-range, overflow, sign, overlong and junk shapes
  task automatic put_value(input bit is_pump);
    case ($urandom_range(11))
      0, 1: put_str($sformatf("%0d", is_pump ? $urandom_range(255) : $urandom_range(1, 65535)));
      2: put_str($sformatf("%0d", is_pump ? $urandom_range(256, 999)
                                          : $urandom_range(65536, 99999)));
      3: repeat ($urandom_range(6, 11)) put_byte(8'(ChZero + $urandom_range(9)));
      4: begin
        put_byte($urandom_range(1) ? ChMinus : ChPlus);
        put_str($sformatf("%0d", $urandom_range(3) == 0 ? 0 : $urandom_range(300)));
      end
      5: begin
        put_byte($urandom_range(1) ? ChMinus : ChPlus);
        repeat ($urandom_range(1, 4)) put_byte(ChZero);
      end
      6: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(2))
            0: put_byte(ChReturn);
            1: put_byte(ChVtab);
            default: put_byte(ChFormfeed);
          endcase
        end
        put_str($sformatf("%0d", $urandom_range(1, 255)));
      end
      7: begin
        put_str($sformatf("%0d", $urandom_range(1, 200)));
        repeat ($urandom_range(1, 3)) put_byte($urandom_range(1) ? near_char()
                                                                 : 8'($urandom_range(255)));
      end
      8: ;
      9: repeat ($urandom_range(12, 14)) put_byte(8'(ChZero + $urandom_range(9)));
      10: begin
        repeat (8) put_byte(ChZero);
        put_str($sformatf("%03d", $urandom_range(1, 255)));
      end
      default: repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(255)));
    endcase
  endtask

  // mostly command-shaped payloads with random content, some noise and damage
  task automatic build_payload();
    bit pump_first;
    bit sel;
    int pos;
    pay.delete();
    if ($urandom_range(99) < 15) begin
      ws_pct = 0;
      repeat ($urandom_range(1, 24)) put_byte($urandom_range(1) ? near_char()
                                                                : 8'($urandom_range(255)));
    end else begin
      ws_pct = ($urandom_range(3) == 0) ? 15 : 0;
      pump_first = 1'($urandom_range(1));
      for (int i = 0; i < 2; i++) begin
        sel = (i == 0) ? pump_first : !pump_first;
        if (i == 1) put_byte(ChAmp);
        put_key(sel);
        put_byte(ChEq);
        put_value(sel);
      end
      // damage a few payloads
      if ($urandom_range(9) == 0) begin
        pos = $urandom_range(pay.size() - 1);
        pay[pos] = 8'($urandom_range(255));
      end
      if ($urandom_range(19) == 0) pay.insert($urandom_range(pay.size()),
                                              $urandom_range(1) ? ChAmp : ChEq);
      if ($urandom_range(19) == 0 && pay.size() > 1) pay.delete($urandom_range(pay.size() - 1));
      if ($urandom_range(39) == 0) pad_to($urandom_range(MaxPayload - 6, MaxPayload + 6));
    end
  endtask

  task automatic random_run(input int nbytes);
    int stop_at;
    stop_at = nsent + nbytes;
    while (nsent < stop_at) begin
      build_payload();
      ship();
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    tx_gap_pct = 19;
    rx_gap_pct = 51;
    stall_req = 0;
    ws_pct = 0;
    nsent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed commands: range edges, key order, signs, saturation, fallback
    ship_str({"pump_id=0&", DurKey, "=1"});
    ship_str({DurKey, "=65535&pump_id=255"});
    ship_str({"pump_id=256&", DurKey, "=10"});
    ship_str({"pump_id=7&", DurKey, "=0"});
    ship_str({"pump_id=-0&", DurKey, "=+5"});
    ship_str({"pump_id=-3&", DurKey, "=5"});
    ship_str({"pump_id=12&", DurKey, "=65536"});
    ship_str({"pump_id=1&", DurKey, "=123456789012"});
    ship_str({"pumpump_id=5&", DurKey, "=6"});
    ship_str({"pump_id=1&&", DurKey, "=2"});
    ship_str({"pump_id==1&", DurKey, "=2"});
    ship_str({"pump_id1&", DurKey, "=2"});

    // leading control characters, junk after digits, saturating value
    pay.delete();
    put_str("pump_id=");
    put_byte(ChReturn);
    put_byte(ChVtab);
    put_byte(ChFormfeed);
    put_str({"4x&", DurKey, "=99999999999"});
    ship();

    // skipped whitespace everywhere
    pay.delete();
    put_str(" pump_id = 5 &");
    put_byte(ChTab);
    put_str({DurKey, "="});
    put_byte(ChNewline);
    put_byte(ChNewline);
    put_str("6");
    ship();

    // nul byte inside a value
    pay.delete();
    put_str("pump_id=5");
    put_byte(8'h00);
    put_str({"&", DurKey, "=6"});
    ship();

    // single-byte payloads
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);

    // length limit: exactly full, then one over
    pay.delete();
    put_str({"pump_id=9&", DurKey, "=300"});
    pad_to(MaxPayload);
    ship();
    pad_to(MaxPayload + 1);
    ship();

    // random payloads under three idling patterns
    random_run(PhaseBytes);
    tx_gap_pct = 51;
    rx_gap_pct = 19;
    random_run(PhaseBytes);
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    stall_req++;
    random_run(PhaseBytes);

    // drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
